[src/pcp_pkg.sv]
// Package for the particle contact projection block.
// Holds the input and result payload structs and fixed field widths.
// No dependencies.
package pcp_pkg;

  localparam int unsigned PosW   = 32;
  localparam int unsigned MassW  = 24;
  localparam int unsigned CountW = 8;
  localparam int unsigned DiamW  = 24;

  typedef struct packed {
    logic signed [PosW-1:0]   first_x;
    logic signed [PosW-1:0]   first_y;
    logic signed [PosW-1:0]   second_x;
    logic signed [PosW-1:0]   second_y;
    logic        [MassW-1:0]  first_inv_mass;
    logic        [MassW-1:0]  second_inv_mass;
    logic        [CountW-1:0] first_count;
    logic        [CountW-1:0] second_count;
    logic                     stable_mode;
  } in_item_t;

  typedef struct packed {
    logic signed [PosW-1:0] first_dx;
    logic signed [PosW-1:0] first_dy;
    logic signed [PosW-1:0] second_dx;
    logic signed [PosW-1:0] second_dy;
    logic                   applied;
    logic                   also_commit;
  } out_item_t;

endpackage

[src/pcp_divider.sv]
// Pipelined restoring divider: one quotient bit per stage, stall-aware.
// Carries a side payload of width SideW alongside the division.
// Depends on nothing.
module pcp_divider #(
  parameter int unsigned NumW  = 40,
  parameter int unsigned DenW  = 25,
  parameter int unsigned SideW = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             adv_i,
  input  logic             vld_i,
  input  logic [NumW-1:0]  num_i,
  input  logic [DenW-1:0]  den_i,
  input  logic [SideW-1:0] side_i,
  output logic             vld_o,
  output logic [NumW-1:0]  quo_o,
  output logic [SideW-1:0] side_o
);

  logic                 vld_q  [NumW+1];
  logic [NumW-1:0]      rem_q  [NumW+1];
  logic [NumW-1:0]      quo_q  [NumW+1];
  logic [NumW-1:0]      numr_q [NumW+1];
  logic [DenW-1:0]      den_q  [NumW+1];
  logic [SideW-1:0]     side_q [NumW+1];

  always_comb begin
    vld_q[0]  = vld_i;
    rem_q[0]  = '0;
    quo_q[0]  = '0;
    numr_q[0] = num_i;
    den_q[0]  = den_i;
    side_q[0] = side_i;
  end

  for (genvar k = 0; k < NumW; k++) begin : g_st
    logic [NumW:0]   trial;
    logic [NumW:0]   dext;
    logic            ge;
    always_comb begin
      trial = {rem_q[k], numr_q[k][NumW-1-k]};
      dext  = (NumW+1)'(den_q[k]);
      ge    = trial >= dext;
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k+1] <= 1'b0;
      end else if (adv_i) begin
        vld_q[k+1] <= vld_q[k];
      end
    end
    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        rem_q[k+1]  <= ge ? NumW'(trial - dext) : trial[NumW-1:0];
        quo_q[k+1]  <= {quo_q[k][NumW-2:0], ge};
        numr_q[k+1] <= numr_q[k];
        den_q[k+1]  <= den_q[k];
        side_q[k+1] <= side_q[k];
      end
    end
  end

  assign vld_o  = vld_q[NumW];
  assign quo_o  = quo_q[NumW];
  assign side_o = side_q[NumW];

  logic unused;
  assign unused = ^{rem_q[NumW], numr_q[NumW], den_q[NumW]};

endmodule

[src/particle_contact_projection.sv]
// Particle contact projection: pipelined PBD contact constraint for 2D pairs.
// Depends on pcp_pkg and pcp_divider.
//
//   channel  | direction | handshake     | payload
//   in       | input     | valid / stall | pcp_pkg::in_item_t
//   out      | output    | valid / stall | pcp_pkg::out_item_t
//   cfg      | input     | valid / ready | contact_diameter, 24 bit
//
// One pair enters per cycle while the output is not stalled. The pipe holds
// three front stages, a (25+FRAC_BITS)-stage share divider, a 25-stage square
// root, the pen product stage, a second (25+FRAC_BITS)-stage divider bank, the
// m*n product stage and the output register.
// The whole pipe advances together; an output stall holds every stage.
// Reset clears valid bits and sets the diameter to 65536 (1.0 at FRAC_BITS 16).
module particle_contact_projection #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  pcp_pkg::in_item_t     in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output pcp_pkg::out_item_t    out_data_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [23:0]           cfg_data_i
);

  localparam int unsigned QW  = FRAC_BITS + 1;       // share/normal width
  localparam int unsigned SW  = 50;                  // S < 2^49
  localparam int unsigned RW  = 25;                  // sqrt bits
  localparam int unsigned NDW = 25 + FRAC_BITS;      // divider numerators
  localparam int unsigned MW  = 25 + 1;              // bound on m

  logic [23:0] diam_q;
  logic        adv;

  assign adv         = !(out_valid_o && out_stall_i);
  assign in_stall_o  = !adv;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      diam_q <= 24'd65536;
    end else if (cfg_valid_i) begin
      diam_q <= cfg_data_i;
    end
  end

  // stage 1: differences
  logic        s1_v_q;
  logic [32:0] s1_ax_q, s1_ay_q;
  logic        s1_nx_q, s1_ny_q, s1_px_q, s1_py_q;
  logic [23:0] s1_w1_q, s1_w2_q;
  logic [7:0]  s1_c1_q, s1_c2_q;
  logic        s1_sm_q;
  logic signed [32:0] dx_c, dy_c;

  always_comb begin
    dx_c = 33'(in_data_i.first_x) - 33'(in_data_i.second_x);
    dy_c = 33'(in_data_i.first_y) - 33'(in_data_i.second_y);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (adv) begin
      s1_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_ax_q <= dx_c[32] ? 33'(-dx_c) : 33'(dx_c);
      s1_ay_q <= dy_c[32] ? 33'(-dy_c) : 33'(dy_c);
      s1_nx_q <= dx_c[32];
      s1_ny_q <= dy_c[32];
      s1_px_q <= !dx_c[32] && (dx_c != '0);
      s1_py_q <= !dy_c[32] && (dy_c != '0);
      s1_w1_q <= in_data_i.first_inv_mass;
      s1_w2_q <= in_data_i.second_inv_mass;
      s1_c1_q <= (in_data_i.first_count == '0) ? 8'd1 : in_data_i.first_count;
      s1_c2_q <= (in_data_i.second_count == '0) ? 8'd1 : in_data_i.second_count;
      s1_sm_q <= in_data_i.stable_mode;
    end
  end

  // stage 2: range check, squares
  logic        s2_v_q, s2_ok_q;
  logic [23:0] s2_ax_q, s2_ay_q;
  logic [47:0] s2_sqx_q, s2_sqy_q, s2_dd_q;
  logic        s2_nx_q, s2_ny_q, s2_px_q, s2_py_q, s2_sm_q;
  logic [23:0] s2_w1_q, s2_w2_q, s2_d_q;
  logic [7:0]  s2_c1_q, s2_c2_q;
  logic        near_c;

  assign near_c = (s1_ax_q < 33'(diam_q)) && (s1_ay_q < 33'(diam_q))
               && !(s1_w1_q == '0 && s1_w2_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else if (adv) begin
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_ok_q  <= near_c;
      s2_ax_q  <= s1_ax_q[23:0];
      s2_ay_q  <= s1_ay_q[23:0];
      s2_sqx_q <= s1_ax_q[23:0] * s1_ax_q[23:0];
      s2_sqy_q <= s1_ay_q[23:0] * s1_ay_q[23:0];
      s2_dd_q  <= diam_q * diam_q;
      s2_d_q   <= diam_q;
      s2_nx_q  <= s1_nx_q; s2_ny_q <= s1_ny_q;
      s2_px_q  <= s1_px_q; s2_py_q <= s1_py_q;
      s2_w1_q  <= s1_w1_q; s2_w2_q <= s1_w2_q;
      s2_c1_q  <= s1_c1_q; s2_c2_q <= s1_c2_q;
      s2_sm_q  <= s1_sm_q;
    end
  end

  // stage 3: sum and final check
  logic        s3_v_q, s3_ok_q;
  logic [SW-1:0] s3_s_q;
  logic [23:0] s3_ax_q, s3_ay_q, s3_d_q, s3_w1_q, s3_w2_q;
  logic        s3_nx_q, s3_ny_q, s3_px_q, s3_py_q, s3_sm_q;
  logic [7:0]  s3_c1_q, s3_c2_q;
  logic [48:0] s_c;

  assign s_c = 49'(s2_sqx_q) + 49'(s2_sqy_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_v_q <= 1'b0;
    end else if (adv) begin
      s3_v_q <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s3_ok_q <= s2_ok_q && (s_c != '0) && (s_c < 49'(s2_dd_q));
      s3_s_q  <= SW'(s_c);
      s3_ax_q <= s2_ax_q; s3_ay_q <= s2_ay_q; s3_d_q <= s2_d_q;
      s3_w1_q <= s2_w1_q; s3_w2_q <= s2_w2_q;
      s3_nx_q <= s2_nx_q; s3_ny_q <= s2_ny_q;
      s3_px_q <= s2_px_q; s3_py_q <= s2_py_q;
      s3_c1_q <= s2_c1_q; s3_c2_q <= s2_c2_q; s3_sm_q <= s2_sm_q;
    end
  end

  // shares: w << F / (w1+w2), runs ahead of the root
  localparam int unsigned SIDE1 = 1 + 24*3 + 4 + 16 + 1 + SW;
  logic              q1_v, q2_v;
  logic [NDW-1:0]    q1, q2;
  logic [SIDE1-1:0]  side_a, side_a_o;
  logic [0:0]        side_b, side_b_o;
  logic [24:0]       wsum_c;

  assign wsum_c = 25'(s3_w1_q) + 25'(s3_w2_q);
  assign side_a = {s3_ok_q, s3_ax_q, s3_ay_q, s3_d_q, s3_nx_q, s3_ny_q,
                   s3_px_q, s3_py_q, s3_c1_q, s3_c2_q, s3_sm_q, s3_s_q};
  assign side_b = 1'b0;

  pcp_divider #(.NumW(NDW), .DenW(25), .SideW(SIDE1)) u_share1 (
    .clk_i, .rst_ni, .adv_i(adv), .vld_i(s3_v_q),
    .num_i(NDW'({s3_w1_q, FRAC_BITS'(0)})), .den_i(wsum_c | 25'(wsum_c == '0)),
    .side_i(side_a), .vld_o(q1_v), .quo_o(q1), .side_o(side_a_o));
  pcp_divider #(.NumW(NDW), .DenW(25), .SideW(1)) u_share2 (
    .clk_i, .rst_ni, .adv_i(adv), .vld_i(s3_v_q),
    .num_i(NDW'({s3_w2_q, FRAC_BITS'(0)})), .den_i(wsum_c | 25'(wsum_c == '0)),
    .side_i(side_b), .vld_o(q2_v), .quo_o(q2), .side_o(side_b_o));

  // square root: one result bit per stage over RW stages
  logic          s4_ok, s4_nx, s4_ny, s4_px, s4_py, s4_sm;
  logic [23:0]   s4_ax, s4_ay, s4_d;
  logic [7:0]    s4_c1, s4_c2;
  logic [SW-1:0] s4_s;
  assign {s4_ok, s4_ax, s4_ay, s4_d, s4_nx, s4_ny, s4_px, s4_py,
          s4_c1, s4_c2, s4_sm, s4_s} = side_a_o;

  logic          rt_v_q  [RW+1];
  logic [SW-1:0] rt_rem_q[RW+1];
  logic [RW-1:0] rt_r_q  [RW+1];
  logic [SW-1:0] rt_s_q  [RW+1];
  logic [QW-1:0] rt_h1_q [RW+1];
  logic [QW-1:0] rt_h2_q [RW+1];
  logic [SIDE1-SW-1:0] rt_sd_q [RW+1];

  always_comb begin
    rt_v_q[0]   = q1_v;
    rt_rem_q[0] = '0;
    rt_r_q[0]   = '0;
    rt_s_q[0]   = s4_s;
    rt_h1_q[0]  = QW'(q1);
    rt_h2_q[0]  = QW'(q2);
    rt_sd_q[0]  = side_a_o[SIDE1-1:SW];
  end

  for (genvar k = 0; k < RW; k++) begin : g_rt
    logic [SW-1:0] rem_sh, trial;
    logic          ge;
    always_comb begin
      rem_sh = {rt_rem_q[k][SW-3:0], rt_s_q[k][SW-1-2*k -: 2]};
      trial  = SW'({rt_r_q[k], 2'b01});
      ge     = rem_sh >= trial;
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        rt_v_q[k+1] <= 1'b0;
      end else if (adv) begin
        rt_v_q[k+1] <= rt_v_q[k];
      end
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        rt_rem_q[k+1] <= ge ? rem_sh - trial : rem_sh;
        rt_r_q[k+1]   <= {rt_r_q[k][RW-2:0], ge};
        rt_s_q[k+1]   <= rt_s_q[k];
        rt_h1_q[k+1]  <= rt_h1_q[k];
        rt_h2_q[k+1]  <= rt_h2_q[k];
        rt_sd_q[k+1]  <= rt_sd_q[k];
      end
    end
  end

  logic          r_ok, r_nx, r_ny, r_px, r_py, r_sm;
  logic [23:0]   r_ax, r_ay, r_d;
  logic [7:0]    r_c1, r_c2;
  logic [RW-1:0] r_dist;
  assign {r_ok, r_ax, r_ay, r_d, r_nx, r_ny, r_px, r_py, r_c1, r_c2, r_sm} =
    rt_sd_q[RW];
  assign r_dist = rt_r_q[RW];

  // stage P: pen * share products
  logic          p_v_q, p_ok_q, p_nx_q, p_ny_q, p_px_q, p_py_q, p_sm_q;
  logic [23:0]   p_ax_q, p_ay_q;
  logic [23:0]   p_dist_q;
  logic [7:0]    p_c1_q, p_c2_q;
  logic [23+QW:0] p_m1_q, p_m2_q;
  logic [23:0]   pen_c;

  assign pen_c = r_d - r_dist[23:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_v_q <= 1'b0;
    end else if (adv) begin
      p_v_q <= rt_v_q[RW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p_ok_q <= r_ok;
      p_m1_q <= pen_c * rt_h1_q[RW];
      p_m2_q <= pen_c * rt_h2_q[RW];
      p_dist_q <= (r_dist[23:0] == '0) ? 24'd1 : r_dist[23:0];
      p_ax_q <= r_ax; p_ay_q <= r_ay;
      p_nx_q <= r_nx; p_ny_q <= r_ny; p_px_q <= r_px; p_py_q <= r_py;
      p_c1_q <= r_c1; p_c2_q <= r_c2; p_sm_q <= r_sm;
    end
  end

  // second divider bank: m = (pen*share >> F)/c and n = (|d| << F)/dist
  localparam int unsigned SIDE2 = 1 + 4 + 1;
  logic           m1_v, m2_v, n1_v, n2_v;
  logic [NDW-1:0] m1, m2, nxq, nyq;
  logic [SIDE2-1:0] sd2, sd2_o;
  logic [0:0]     dm1, dm2, dm3;

  assign sd2 = {p_ok_q, p_nx_q, p_ny_q, p_px_q, p_py_q, p_sm_q};

  pcp_divider #(.NumW(NDW), .DenW(24), .SideW(SIDE2)) u_m1 (
    .clk_i, .rst_ni, .adv_i(adv), .vld_i(p_v_q),
    .num_i(NDW'(p_m1_q >> FRAC_BITS)), .den_i(24'(p_c1_q)),
    .side_i(sd2), .vld_o(m1_v), .quo_o(m1), .side_o(sd2_o));
  pcp_divider #(.NumW(NDW), .DenW(24), .SideW(1)) u_m2 (
    .clk_i, .rst_ni, .adv_i(adv), .vld_i(p_v_q),
    .num_i(NDW'(p_m2_q >> FRAC_BITS)), .den_i(24'(p_c2_q)),
    .side_i(1'b0), .vld_o(m2_v), .quo_o(m2), .side_o(dm1));
  pcp_divider #(.NumW(NDW), .DenW(24), .SideW(1)) u_nx (
    .clk_i, .rst_ni, .adv_i(adv), .vld_i(p_v_q),
    .num_i(NDW'({p_ax_q, FRAC_BITS'(0)})), .den_i(p_dist_q),
    .side_i(1'b0), .vld_o(n1_v), .quo_o(nxq), .side_o(dm2));
  pcp_divider #(.NumW(NDW), .DenW(24), .SideW(1)) u_ny (
    .clk_i, .rst_ni, .adv_i(adv), .vld_i(p_v_q),
    .num_i(NDW'({p_ay_q, FRAC_BITS'(0)})), .den_i(p_dist_q),
    .side_i(1'b0), .vld_o(n2_v), .quo_o(nyq), .side_o(dm3));

  // stage M: m * n products
  logic          x_ok, x_nx, x_ny, x_px, x_py, x_sm;
  assign {x_ok, x_nx, x_ny, x_px, x_py, x_sm} = sd2_o;

  logic          mm_v_q, mm_ok_q, mm_nx_q, mm_ny_q, mm_px_q, mm_py_q, mm_sm_q;
  logic [MW+QW-1:0] mm_a_q, mm_b_q, mm_c_q, mm_d_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mm_v_q <= 1'b0;
    end else if (adv) begin
      mm_v_q <= m1_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      mm_ok_q <= x_ok;
      mm_a_q  <= MW'(m1) * QW'(nxq);
      mm_b_q  <= MW'(m1) * QW'(nyq);
      mm_c_q  <= MW'(m2) * QW'(nxq);
      mm_d_q  <= MW'(m2) * QW'(nyq);
      mm_nx_q <= x_nx; mm_ny_q <= x_ny; mm_px_q <= x_px; mm_py_q <= x_py;
      mm_sm_q <= x_sm;
    end
  end

  function automatic logic [31:0] sat_f(input logic [MW+QW-1:0] p, input logic neg);
    logic [MW+QW-1:0] mg;
    mg = p >> FRAC_BITS;
    if (neg) begin
      sat_f = (mg > (MW+QW)'(32'h8000_0000)) ? 32'h8000_0000 : 32'(-mg);
    end else begin
      sat_f = (mg > (MW+QW)'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : mg[31:0];
    end
  endfunction

  // output register
  logic               o_v_q;
  pcp_pkg::out_item_t o_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_v_q <= 1'b0;
    end else if (adv) begin
      o_v_q <= mm_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      o_q.first_dx    <= mm_ok_q ? sat_f(mm_a_q, mm_nx_q) : '0;
      o_q.first_dy    <= mm_ok_q ? sat_f(mm_b_q, mm_ny_q) : '0;
      o_q.second_dx   <= mm_ok_q ? sat_f(mm_c_q, mm_px_q) : '0;
      o_q.second_dy   <= mm_ok_q ? sat_f(mm_d_q, mm_py_q) : '0;
      o_q.applied     <= mm_ok_q;
      o_q.also_commit <= mm_sm_q;
    end
  end

  assign out_valid_o = o_v_q;
  assign out_data_o  = o_q;

  logic unused;
  assign unused = ^{q2_v, side_b_o, m2_v, n1_v, n2_v, dm1, dm2, dm3,
                    q1[NDW-1:QW], q2[NDW-1:QW], m1[NDW-1:MW], m2[NDW-1:MW],
                    nxq[NDW-1:QW], nyq[NDW-1:QW], r_dist[RW-1:24],
                    rt_rem_q[RW], rt_s_q[RW]};

endmodule
